[design/atrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrm_pkg
// Types and codes shared by the modem response matcher: parser phases,
// item action codes, result kinds, status codes and register indexes.
// ----------------------------------------------------------------------------
package atrm_pkg;

  // control characters
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // input item actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  // unassigned action code, ignored
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_CAP_END = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // final status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_FIRST_PAT  = 3'd1;
  localparam logic [2:0] REG_FIRST_LEN  = 3'd2;
  localparam logic [2:0] REG_SECOND_PAT = 3'd3;
  localparam logic [2:0] REG_SECOND_LEN = 3'd4;
  localparam logic [2:0] REG_CAP_LIMIT  = 3'd5;
  localparam logic [2:0] REG_TIMEOUT    = 3'd6;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_LINE_START = 6'b000010,
    PH_SKIP       = 6'b000100,
    PH_MATCH      = 6'b001000,
    PH_AFTER      = 6'b010000,
    PH_BAD        = 6'b100000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] captured_byte;
    logic [1:0] status;
    logic [6:0] capture_count;
  } result_t;

endpackage

[design/at_response_matcher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_matcher_top
// Byte-wise matcher for a modem's reply to a text command: skips echo
// lines, matches the expected token, captures a query answer and reports
// ok, invalid or timeout.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  in_       slave      in_tvalid/in_tready    tdata: data_byte, tuser: action
//  out_      master     out_tvalid/out_tready  tdata: byte, status, count;
//                                              tuser: kind
//  cfg_      apb slave  psel/penable, pready=1 64-bit registers at 8*index
//
//  one item per clock sustained while out_ is not stalled; an input item is
//  held in the input register and its result item in the result register on out_.
//  the parser state updates once per item in the input-register stage.
//  reset (rst_n low, synchronous) clears both stages and disarms the parser;
//  registers return to their default values.
//  a stall on out_ holds the result register and then the input register,
//  and in_tready drops only when both are full.
//
module at_response_matcher_top
  import atrm_pkg::*;
#(
  parameter int PATTERN_MAX = 8,
  parameter int CAPTURE_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] captured_byte, [9:8] status,
                                  // [16:10] capture_count, [23:17] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [4:0] PAT_MAX_W = 5'(PATTERN_MAX);
  localparam logic [8:0] CAP_MAX_W = 9'(CAPTURE_MAX);

  // configuration registers
  logic        mode_r;
  logic [63:0] first_pat_r;
  logic [3:0]  first_len_r;
  logic [63:0] second_pat_r;
  logic [3:0]  second_len_r;
  logic [6:0]  cap_limit_r;
  logic [15:0] timeout_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[5:3];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      first_pat_r  <= 64'd19279;
      first_len_r  <= 4'd2;
      second_pat_r <= 64'd19279;
      second_len_r <= 4'd2;
      cap_limit_r  <= 7'd64;
      timeout_r    <= 16'd1000;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:       mode_r       <= cfg_pwdata[0];
        REG_FIRST_PAT:  first_pat_r  <= cfg_pwdata;
        REG_FIRST_LEN:  first_len_r  <= cfg_pwdata[3:0];
        REG_SECOND_PAT: second_pat_r <= cfg_pwdata;
        REG_SECOND_LEN: second_len_r <= cfg_pwdata[3:0];
        REG_CAP_LIMIT:  cap_limit_r  <= cfg_pwdata[6:0];
        REG_TIMEOUT:    timeout_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_MODE:       cfg_prdata = {63'd0, mode_r};
      REG_FIRST_PAT:  cfg_prdata = first_pat_r;
      REG_FIRST_LEN:  cfg_prdata = {60'd0, first_len_r};
      REG_SECOND_PAT: cfg_prdata = second_pat_r;
      REG_SECOND_LEN: cfg_prdata = {60'd0, second_len_r};
      REG_CAP_LIMIT:  cfg_prdata = {57'd0, cap_limit_r};
      REG_TIMEOUT:    cfg_prdata = {48'd0, timeout_r};
      default:        cfg_prdata = 64'd0;
    endcase
  end

  // pipeline control
  logic       s1_valid_r;
  logic [1:0] s1_action_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       out_free;
  logic       s1_fire;
  logic       in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // parser state
  phase_t     phase_r, phase_nxt;
  logic [3:0] match_pos_r, match_pos_nxt;
  logic       in_first_r, in_first_nxt;
  logic [6:0] captured_r, captured_nxt;
  logic [15:0] quiet_r, quiet_nxt;

  logic    res_valid;
  result_t res;

  // token selection, clamped length and current character
  logic [63:0] tok_pat;
  logic [4:0]  tok_len_raw;
  logic [4:0]  tok_len;
  logic [7:0]  tok_char;
  logic [4:0]  pos_inc;
  logic [8:0]  limit;
  logic        query;

  always_comb begin
    tok_pat     = in_first_r ? first_pat_r : second_pat_r;
    tok_len_raw = {1'b0, (in_first_r ? first_len_r : second_len_r)};
    tok_len     = (tok_len_raw > PAT_MAX_W) ? PAT_MAX_W : tok_len_raw;
    tok_char    = match_pos_r[3] ? 8'd0 : tok_pat[{match_pos_r[2:0], 3'b000} +: 8];
    pos_inc     = {1'b0, match_pos_r} + 5'd1;
    limit       = ({2'b00, cap_limit_r} > CAP_MAX_W) ? CAP_MAX_W : {2'b00, cap_limit_r};
    query       = mode_r;
  end

  // per-item phase update and result
  always_comb begin
    phase_nxt     = phase_r;
    match_pos_nxt = match_pos_r;
    in_first_nxt  = in_first_r;
    captured_nxt  = captured_r;
    quiet_nxt     = quiet_r;
    res_valid     = 1'b0;
    res           = '0;
    res.capture_count = captured_r;

    if (s1_action_r == ACT_START) begin
      phase_nxt     = PH_LINE_START;
      match_pos_nxt = 4'd0;
      in_first_nxt  = 1'b1;
      captured_nxt  = 7'd0;
      quiet_nxt     = 16'd0;
      res.capture_count = 7'd0;
      // query with no room for an answer finishes at once
      if (query && (limit == 9'd0)) begin
        phase_nxt  = PH_IDLE;
        res_valid  = 1'b1;
        res.kind   = KIND_STATUS;
        res.status = ST_OK;
      end
    end else if (phase_r == PH_IDLE || s1_action_r == ACT_NONE) begin
      // ignored item
    end else if (s1_action_r == ACT_TICK) begin
      quiet_nxt = (quiet_r == 16'hFFFF) ? quiet_r : quiet_r + 16'd1;
      if (quiet_nxt >= timeout_r) begin
        phase_nxt  = PH_IDLE;
        res_valid  = 1'b1;
        res.kind   = KIND_STATUS;
        res.status = ST_TIMEOUT;
      end
    end else begin
      quiet_nxt = 16'd0;
      unique case (phase_r)
        PH_LINE_START: begin
          if (s1_byte_r == CH_LF) begin
            match_pos_nxt = 4'd0;
            phase_nxt     = (tok_len == 5'd0) ? PH_AFTER : PH_MATCH;
          end else if (s1_byte_r != CH_CR) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (s1_byte_r == CH_LF) phase_nxt = PH_LINE_START;
        end
        PH_MATCH: begin
          if (s1_byte_r == tok_char) begin
            match_pos_nxt = pos_inc[3:0];
            if (pos_inc >= tok_len) phase_nxt = PH_AFTER;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_AFTER: begin
          if (query && in_first_r) begin
            // capture the answer line until its end or the limit
            if (s1_byte_r == CH_LF || s1_byte_r == CH_CR ||
                {2'b00, captured_r} >= limit) begin
              in_first_nxt  = 1'b0;
              match_pos_nxt = 4'd0;
              phase_nxt     = PH_SKIP;
              res_valid     = 1'b1;
              res.kind      = KIND_CAP_END;
            end else begin
              captured_nxt      = captured_r + 7'd1;
              res_valid         = 1'b1;
              res.kind          = KIND_BYTE;
              res.captured_byte = s1_byte_r;
              res.capture_count = captured_r + 7'd1;
            end
          end else if (s1_byte_r == CH_LF) begin
            phase_nxt  = PH_IDLE;
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_OK;
          end
        end
        PH_BAD: begin
          if (s1_byte_r == CH_LF) begin
            phase_nxt  = PH_IDLE;
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_INVALID;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_tuser;
      s1_byte_r   <= in_tdata;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      match_pos_r <= 4'd0;
      in_first_r  <= 1'b1;
      captured_r  <= 7'd0;
      quiet_r     <= 16'd0;
    end else if (s1_fire) begin
      phase_r     <= phase_nxt;
      match_pos_r <= match_pos_nxt;
      in_first_r  <= in_first_nxt;
      captured_r  <= captured_nxt;
      quiet_r     <= quiet_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'd0, out_res_r.capture_count, out_res_r.status,
                       out_res_r.captured_byte};

  // checks
  a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_valid) |=> out_valid_r)
    else $error("result of an item did not reach the output register");

  a_status_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res_valid && res.kind == KIND_STATUS) |=> (phase_r == PH_IDLE))
    else $error("parser still armed after a final status");

  a_capture_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (captured_r != $past(captured_r)) |->
      (captured_r == 7'($past(captured_r) + 7'd1) || captured_r == 7'd0))
    else $error("capture count moved by more than one");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a stage was free");

endmodule

[tb/at_response_matcher_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_matcher_top_tb
// Self-checking bench for the modem response matcher. A short directed table
// walks an echoed expect-mode exchange after reset. Then a series of register
// settings follows, each driving randomized, mostly well-formed replies (echo
// lines, tokens, query answers, stray ticks, broken tokens and noise). Every
// result item is checked field by field against the table or a cycle-free model.
// ----------------------------------------------------------------------------
module at_response_matcher_top_tb
  import atrm_pkg::*;
();

  localparam int          PATTERN_MAX = 8;
  localparam int          CAPTURE_MAX = 64;
  localparam int          LONG_HOLD   = 100;
  localparam result_t     RES_OK      = '{KIND_STATUS, 8'h00, ST_OK, 7'd0};
  localparam result_t     RES_INVALID = '{KIND_STATUS, 8'h00, ST_INVALID, 7'd0};

  typedef struct {
    logic [1:0] act;
    logic [7:0] data;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic [1:0]  in_tuser;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [7:0] captured_byte, [9:8] status, [16:10] capture_count
  logic [1:0]  out_tuser;  // [1:0] kind
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // register copies
  bit          cf_mode;
  logic [63:0] cf_first_pat, cf_second_pat;
  int unsigned cf_first_len, cf_second_len, cf_limit, cf_timeout;

  // parser copy
  phase_t      ps_phase;
  int unsigned ps_pos;
  bit          ps_first;
  int unsigned ps_captured;
  int unsigned ps_quiet;

  result_t     pending_results[$];
  int unsigned error_count;
  int unsigned item_count;
  bit          tx_gaps_on;
  bit          rx_stalls_on;
  bit          hold_req;

  // echoed "A", then "OK" on its own line; then a restart and a bad token
  dir_row_t dir_rows [0:22] = '{
    '{ACT_TICK,  8'hFF, 1'b0, '0},
    '{ACT_BYTE,  8'h00, 1'b0, '0},
    '{ACT_NONE,  8'hA5, 1'b0, '0},
    '{ACT_START, 8'h00, 1'b0, '0},
    '{ACT_BYTE,  8'h41, 1'b0, '0},
    '{ACT_BYTE,  8'hFF, 1'b0, '0},
    '{ACT_BYTE,  CH_CR, 1'b0, '0},
    '{ACT_BYTE,  CH_LF, 1'b0, '0},
    '{ACT_BYTE,  CH_CR, 1'b0, '0},
    '{ACT_BYTE,  CH_LF, 1'b0, '0},
    '{ACT_BYTE,  8'h4F, 1'b0, '0},
    '{ACT_TICK,  8'h00, 1'b0, '0},
    '{ACT_BYTE,  8'h4B, 1'b0, '0},
    '{ACT_BYTE,  CH_CR, 1'b0, '0},
    '{ACT_BYTE,  CH_LF, 1'b1, RES_OK},
    '{ACT_BYTE,  CH_LF, 1'b0, '0},
    '{ACT_START, 8'h00, 1'b0, '0},
    '{ACT_START, 8'h7F, 1'b0, '0},
    '{ACT_BYTE,  CH_LF, 1'b0, '0},
    '{ACT_BYTE,  8'h4F, 1'b0, '0},
    '{ACT_BYTE,  8'h00, 1'b0, '0},
    '{ACT_BYTE,  8'h80, 1'b0, '0},
    '{ACT_BYTE,  CH_LF, 1'b1, RES_INVALID}
  };

  at_response_matcher_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (error_count < 100)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic result_t make_result(input logic [1:0] k, input logic [7:0] c,
                                          input logic [1:0] s);
    result_t r;
    r.kind          = k;
    r.captured_byte = c;
    r.status        = s;
    r.capture_count = 7'(ps_captured);
    return r;
  endfunction

  // one parser step; returns 1 when the item yields a result
  function automatic bit parse_step(input logic [1:0] act, input logic [7:0] b,
                                    output result_t res);
    int unsigned lim, tlen;
    logic [63:0] tpat;
    logic [7:0]  tch;
    res = '0;
    lim = (cf_limit > CAPTURE_MAX) ? CAPTURE_MAX : cf_limit;
    if (act == ACT_START) begin
      ps_phase    = PH_LINE_START;
      ps_pos      = 0;
      ps_first    = 1'b1;
      ps_captured = 0;
      ps_quiet    = 0;
      // zero capture limit in query mode: done at once
      if (cf_mode && lim == 0) begin
        ps_phase = PH_IDLE;
        res = make_result(KIND_STATUS, 8'h00, ST_OK);
        return 1'b1;
      end
      return 1'b0;
    end
    if (ps_phase == PH_IDLE || act == ACT_NONE)
      return 1'b0;
    // tick: saturating quiet counter
    if (act == ACT_TICK) begin
      if (ps_quiet < 65535)
        ps_quiet++;
      if (ps_quiet >= cf_timeout) begin
        ps_phase = PH_IDLE;
        res = make_result(KIND_STATUS, 8'h00, ST_TIMEOUT);
        return 1'b1;
      end
      return 1'b0;
    end
    ps_quiet = 0;
    tlen = ps_first ? cf_first_len : cf_second_len;
    if (tlen > PATTERN_MAX)
      tlen = PATTERN_MAX;
    tpat = ps_first ? cf_first_pat : cf_second_pat;
    tch  = (ps_pos < 8) ? tpat[8*ps_pos +: 8] : 8'h00;
    case (ps_phase)
      PH_LINE_START: begin
        if (b == CH_LF) begin
          ps_pos   = 0;
          ps_phase = (tlen == 0) ? PH_AFTER : PH_MATCH;
        end else if (b != CH_CR) begin
          ps_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == CH_LF)
          ps_phase = PH_LINE_START;
      end
      PH_MATCH: begin
        if (b == tch) begin
          ps_pos++;
          if (ps_pos >= tlen)
            ps_phase = PH_AFTER;
        end else begin
          ps_phase = PH_BAD;
        end
      end
      PH_AFTER: begin
        // query answer capture
        if (cf_mode && ps_first) begin
          if (b == CH_LF || b == CH_CR || ps_captured >= lim) begin
            ps_first = 1'b0;
            ps_pos   = 0;
            ps_phase = PH_SKIP;
            res = make_result(KIND_CAP_END, 8'h00, ST_OK);
            return 1'b1;
          end
          ps_captured++;
          res = make_result(KIND_BYTE, b, ST_OK);
          return 1'b1;
        end
        if (b == CH_LF) begin
          ps_phase = PH_IDLE;
          res = make_result(KIND_STATUS, 8'h00, ST_OK);
          return 1'b1;
        end
      end
      PH_BAD: begin
        if (b == CH_LF) begin
          ps_phase = PH_IDLE;
          res = make_result(KIND_STATUS, 8'h00, ST_INVALID);
          return 1'b1;
        end
      end
      default: ps_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // offer one item, wait for the handshake, then predict
  task automatic send_item(input logic [1:0] act, input logic [7:0] b, input bit typed,
                           input result_t want);
    result_t got;
    bit      has;
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    item_count++;
    has = parse_step(act, b, got);
    if (typed)
      pending_results.push_back(want);
    else if (has)
      pending_results.push_back(got);
  endtask

  // received character, sometimes preceded by ticks or a dead action
  task automatic send_byte(input logic [7:0] c);
    if ($urandom_range(0, 15) == 0)
      repeat ($urandom_range(1, 3)) send_item(ACT_TICK, 8'($urandom), 1'b0, '0);
    else if ($urandom_range(0, 40) == 0)
      send_item(ACT_NONE, 8'($urandom), 1'b0, '0);
    send_item(ACT_BYTE, c, 1'b0, '0);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  // token characters, now and then with one character spoiled
  task automatic send_token(input bit first, output bit broken);
    logic [63:0] pat;
    int unsigned tl, bad_at;
    logic [7:0]  c;
    pat = first ? cf_first_pat : cf_second_pat;
    tl  = first ? cf_first_len : cf_second_len;
    if (tl > PATTERN_MAX)
      tl = PATTERN_MAX;
    broken = (tl != 0) && ($urandom_range(0, 6) == 0);
    bad_at = broken ? $urandom_range(0, tl - 1) : tl;
    for (int unsigned i = 0; i < tl; i++) begin
      c = pat[8*i +: 8];
      if (i == bad_at)
        c = c ^ 8'($urandom_range(1, 255));
      send_item(ACT_BYTE, c, 1'b0, '0);
    end
  endtask

  // one modem exchange, mostly well formed
  task automatic send_exchange();
    int unsigned style, n;
    bit          broken;
    style = $urandom_range(0, 11);
    if (style == 0) begin
      // raw noise
      repeat ($urandom_range(3, 10))
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
      return;
    end
    send_item(ACT_START, 8'($urandom), 1'b0, '0);
    if (style == 1) begin
      // no bytes at all: run into the timeout where it is short
      repeat ((cf_timeout > 30 ? 30 : cf_timeout) + 1)
        send_item(ACT_TICK, 8'($urandom), 1'b0, '0);
      return;
    end
    // echoed command lines
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 6)) send_byte(text_byte());
      send_byte(CH_CR);
      send_byte(CH_LF);
    end
    if ($urandom_range(0, 1) == 1)
      send_byte(CH_CR);
    send_byte(CH_LF);
    send_token(1'b1, broken);
    // query answer, sometimes past the capture limit, then the closing token
    if (cf_mode && !broken) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 8);
      repeat (n) send_byte(text_byte());
      send_byte(CH_CR);
      send_byte(CH_LF);
      if ($urandom_range(0, 1) == 1)
        send_byte(CH_CR);
      send_byte(CH_LF);
      send_token(1'b0, broken);
    end
    repeat ($urandom_range(0, 3)) send_byte(text_byte());
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // wait until every expected result is out and the pipe has emptied
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:       cf_mode       = val[0];
      REG_FIRST_PAT:  cf_first_pat  = val;
      REG_FIRST_LEN:  cf_first_len  = val[3:0];
      REG_SECOND_PAT: cf_second_pat = val;
      REG_SECOND_LEN: cf_second_len = val[3:0];
      REG_CAP_LIMIT:  cf_limit      = val[6:0];
      REG_TIMEOUT:    cf_timeout    = val[15:0];
      default: ;
    endcase
  endtask

  // new register setting, then random exchanges
  task automatic run_phase(input bit md, input logic [63:0] fp, input logic [3:0] fl,
                           input logic [63:0] sp, input logic [3:0] sl,
                           input logic [6:0] lim, input logic [15:0] tmo,
                           input int unsigned quota, input bit squeeze);
    int unsigned base;
    bit          broken;
    settle();
    cfg_write(REG_MODE, 64'(md));
    cfg_write(REG_FIRST_PAT, fp);
    cfg_write(REG_FIRST_LEN, 64'(fl));
    cfg_write(REG_SECOND_PAT, sp);
    cfg_write(REG_SECOND_LEN, 64'(sl));
    cfg_write(REG_CAP_LIMIT, 64'(lim));
    cfg_write(REG_TIMEOUT, 64'(tmo));
    // long receiver hold while a long answer keeps coming
    if (squeeze) begin
      hold_req = 1'b1;
      send_item(ACT_START, 8'h00, 1'b0, '0);
      send_item(ACT_BYTE, CH_LF, 1'b0, '0);
      send_item(ACT_BYTE, cf_first_pat[7:0], 1'b0, '0);
      repeat (30) send_item(ACT_BYTE, text_byte(), 1'b0, '0);
      send_item(ACT_BYTE, CH_CR, 1'b0, '0);
      send_item(ACT_BYTE, CH_LF, 1'b0, '0);
      send_item(ACT_BYTE, CH_LF, 1'b0, '0);
      send_token(1'b0, broken);
      send_item(ACT_BYTE, CH_LF, 1'b0, '0);
    end
    base = item_count;
    while (item_count - base < quota) send_exchange();
  endtask

  // result side ready, with random stalls and one long hold on request
  initial begin : result_sink
    int unsigned n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, kind", out_tuser, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.kind)
          flag_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[7:0] != want.captured_byte)
          flag_mismatch("captured_byte", out_tdata[7:0], want.captured_byte);
        if (out_tdata[9:8] != want.status)
          flag_mismatch("status", out_tdata[9:8], want.status);
        if (out_tdata[16:10] != want.capture_count)
          flag_mismatch("capture_count", out_tdata[16:10], want.capture_count);
      end
    end
  end

  initial begin : stimulus
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tuser    <= ACT_START;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    // register defaults and an idle parser
    cf_mode       = 1'b0;
    cf_first_pat  = 64'd19279;
    cf_first_len  = 2;
    cf_second_pat = 64'd19279;
    cf_second_len = 2;
    cf_limit      = 64;
    cf_timeout    = 1000;
    ps_phase      = PH_IDLE;
    ps_pos        = 0;
    ps_first      = 1'b1;
    ps_captured   = 0;
    ps_quiet      = 0;
    error_count   = 0;
    item_count    = 0;
    hold_req      = 1'b0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table on the reset setting
    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);

    // register settings, extremes among them
    run_phase(1'b0, {$urandom, $urandom}, 4'd2, {$urandom, $urandom}, 4'd2,
              7'd64, 16'd6, 60, 1'b0);
    run_phase(1'b1, {$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 4'd8,
              7'd64, 16'd1000, 60, 1'b0);
    run_phase(1'b1, {$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd3,
              7'd1, 16'd5, 60, 1'b0);
    run_phase(1'b1, {$urandom, $urandom}, 4'd3, {$urandom, $urandom}, 4'd0,
              7'd127, 16'd0, 60, 1'b0);
    run_phase(1'b1, {$urandom, $urandom}, 4'd15, {$urandom, $urandom}, 4'd15,
              7'd0, 16'hFFFF, 20, 1'b0);
    run_phase(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 4'd4,
              7'd5, 16'd3, 60, 1'b0);
    run_phase(1'b0, 64'h0, 4'd4, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1,
              7'd64, 16'd2, 60, 1'b0);
    // a stretch with no idling on either side
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    run_phase(1'b1, {$urandom, $urandom}, 4'd5, {$urandom, $urandom}, 4'd2,
              7'd7, 16'd20, 60, 1'b0);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    run_phase(1'b0, {$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd9,
              7'd3, 16'd4, 60, 1'b0);
    run_phase(1'b1, {$urandom, $urandom}, 4'd1, {$urandom, $urandom}, 4'd2,
              7'd64, 16'd1000, 60, 1'b1);
    // closing part at full rate
    settle();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    run_phase(1'b1, {$urandom, $urandom}, 4'd2, {$urandom, $urandom}, 4'd2,
              7'd10, 16'd9, 55, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("results never delivered", pending_results.size(), 0);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[at_response_matcher_top.f]
design/atrm_pkg.sv
design/at_response_matcher_top.sv
tb/at_response_matcher_top_tb.sv
